// ----- sv/nja_pkg.sv -----
package nja_pkg;

    localparam int OPCODE_W    = 3;
    localparam int JOB_W       = 4;
    localparam int TIME_W      = 32;
    localparam int STOP_MODE_W = 2;
    localparam int TOTAL_W     = 64;
    localparam int LEVEL_W     = 4;
    localparam int ERR_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam int DEF_NUM_JOBS    = 16;
    localparam int DEF_STACK_SLOTS = 8;

    localparam logic [JOB_W-1:0] RST_OVERHEAD_JOB  = 4'd15;
    localparam logic [JOB_W-1:0] RST_STOP_BASE_JOB = 4'd12;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INIT   = 3'd0,
        OP_SWITCH = 3'd1,
        OP_PUSH   = 3'd2,
        OP_POP    = 3'd3,
        OP_STOP   = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_PUSH_FULL  = 2'd1,
        ERR_POP_EMPTY  = 2'd2,
        ERR_STOP_RANGE = 2'd3
    } err_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERHEAD_JOB = 1'd0,
        CFG_STOP_BASE    = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stack_sts_t;

    typedef struct packed {
        logic              clear;
        logic              charge;
        logic              stop_en;
        logic              rd_zero;
        logic [TIME_W-1:0] d_active;
        logic [TIME_W-1:0] d_overhead;
        logic [TIME_W-1:0] amount;
    } totals_ctl_t;

endpackage

// ----- sv/nja_stack.sv -----
module nja_stack #(
    parameter int STACK_SLOTS = 8,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  nja_pkg::stack_ctl_t   ctl,
    input  logic [IDX_W-1:0]      push_data,
    output logic [IDX_W-1:0]      top,
    output nja_pkg::stack_sts_t   sts,
    output logic [CNT_W-1:0]      max_next
);
    import nja_pkg::*;

    logic [IDX_W-1:0] slot_reg [STACK_SLOTS];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] max_reg;
    logic             push_ok, pop_ok;

    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == CNT_W'(STACK_SLOTS));
    assign push_ok   = ctl.push && !sts.full;
    assign pop_ok    = ctl.pop && !sts.empty;
    assign top       = slot_reg[0];

    always_comb begin
        count_next = count_reg;
        max_next   = max_reg;
        if (ctl.clear) begin
            count_next = '0;
            max_next   = '0;
        end else if (push_ok) begin
            count_next = count_reg + 1'b1;
            if (count_next > max_reg) begin
                max_next = count_next;
            end
        end else if (pop_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            max_reg   <= '0;
        end else begin
            count_reg <= count_next;
            max_reg   <= max_next;
        end
    end

    // shift stack: slot 0 is the top of stack
    for (genvar i = 0; i < STACK_SLOTS; i++) begin : g_slot
        always_ff @(posedge aclk) begin
            if (push_ok) begin
                if (i == 0) begin
                    slot_reg[i] <= push_data;
                end else begin
                    slot_reg[i] <= slot_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (pop_ok && (i < STACK_SLOTS - 1)) begin
                slot_reg[i] <= slot_reg[(i < STACK_SLOTS - 1) ? i + 1 : i];
            end
        end
    end

endmodule

// ----- sv/nja_totals.sv -----
module nja_totals #(
    parameter int NUM_JOBS = 16,
    parameter int IDX_W    = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nja_pkg::totals_ctl_t          ctl,
    input  logic [IDX_W-1:0]              act_idx,
    input  logic [IDX_W-1:0]              ovh_idx,
    input  logic [IDX_W-1:0]              stop_idx,
    input  logic [IDX_W-1:0]              rd_idx,
    input  logic                          upd_en,
    output logic [nja_pkg::TOTAL_W-1:0]   rd_total
);
    import nja_pkg::*;

    localparam int INC_W = TIME_W + 2;

    logic [TOTAL_W-1:0] tot_reg  [NUM_JOBS];
    logic [TOTAL_W-1:0] tot_next [NUM_JOBS];
    logic [INC_W-1:0]   inc      [NUM_JOBS];

    // one accumulator lane per job; up to three 32-bit terms fold into one add
    always_comb begin
        for (int j = 0; j < NUM_JOBS; j++) begin
            inc[j] = '0;
            if (ctl.charge && (act_idx == IDX_W'(j))) begin
                inc[j] = inc[j] + INC_W'(ctl.d_active);
            end
            if (ctl.charge && (ovh_idx == IDX_W'(j))) begin
                inc[j] = inc[j] + INC_W'(ctl.d_overhead);
            end
            if (ctl.stop_en && (stop_idx == IDX_W'(j))) begin
                inc[j] = inc[j] + INC_W'(ctl.amount);
            end
            tot_next[j] = ctl.clear ? '0 : tot_reg[j] + TOTAL_W'(inc[j]);
        end
    end

    assign rd_total = ctl.rd_zero ? '0 : tot_next[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_JOBS; j++) begin
                tot_reg[j] <= '0;
            end
        end else if (upd_en) begin
            for (int j = 0; j < NUM_JOBS; j++) begin
                tot_reg[j] <= tot_next[j];
            end
        end
    end

endmodule

// ----- sv/nested_job_time_accounting.sv -----
// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    opcode, job, entry/exit time, stop amount/mode
// m_       out        m_valid / m_ready    total_time, current_job, deepest_level, error_code
// cfg_     in         cfg_wr_en            cfg_index, cfg_wdata (no read-back)
//
// One transaction per cycle unless m_ready stalls; m_valid is set once the input advances.
// The event is resolved in one pass between the input register and the result register:
// per-job accumulator lanes plus a shift-register job stack.
// Synchronous active-low reset clears totals, stack depth, active job and mark time.
// s_ready stays high while the input stage is empty or the result register can drain.
module nested_job_time_accounting #(
    parameter int NUM_JOBS    = nja_pkg::DEF_NUM_JOBS,
    parameter int STACK_SLOTS = nja_pkg::DEF_STACK_SLOTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [nja_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nja_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [nja_pkg::OPCODE_W-1:0]     s_opcode,
    input  logic [nja_pkg::JOB_W-1:0]        s_job,
    input  logic [nja_pkg::TIME_W-1:0]       s_entry_time,
    input  logic [nja_pkg::TIME_W-1:0]       s_exit_time,
    input  logic [nja_pkg::TIME_W-1:0]       s_stop_amount,
    input  logic [nja_pkg::STOP_MODE_W-1:0]  s_stop_mode,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [nja_pkg::TOTAL_W-1:0]      m_total_time,
    output logic [nja_pkg::JOB_W-1:0]        m_current_job,
    output logic [nja_pkg::LEVEL_W-1:0]      m_deepest_level,
    output logic [nja_pkg::ERR_W-1:0]        m_error_code
);
    import nja_pkg::*;

    localparam int IDX_W  = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
    localparam int CNT_W  = $clog2(STACK_SLOTS + 1);
    localparam int SIDX_W = JOB_W + 1;

    function automatic logic [IDX_W-1:0] job_wrap(input logic [JOB_W-1:0] v);
        logic [JOB_W:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (int'(r) >= NUM_JOBS) begin
                r = r - (JOB_W+1)'(NUM_JOBS);
            end
        end
        return IDX_W'(r);
    endfunction

    // config
    logic [JOB_W-1:0] overhead_job_reg;
    logic [JOB_W-1:0] stop_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overhead_job_reg <= RST_OVERHEAD_JOB;
            stop_base_reg    <= RST_STOP_BASE_JOB;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OVERHEAD_JOB: overhead_job_reg <= cfg_wdata;
                CFG_STOP_BASE:    stop_base_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    logic                   in_valid_reg;
    logic [OPCODE_W-1:0]    op_reg;
    logic [JOB_W-1:0]       job_reg;
    logic [TIME_W-1:0]      entry_reg;
    logic [TIME_W-1:0]      exit_reg;
    logic [TIME_W-1:0]      amount_reg;
    logic [STOP_MODE_W-1:0] mode_reg;
    logic                   advance;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= s_opcode;
            job_reg    <= s_job;
            entry_reg  <= s_entry_time;
            exit_reg   <= s_exit_time;
            amount_reg <= s_stop_amount;
            mode_reg   <= s_stop_mode;
        end
    end

    // event decode
    op_t               op;
    logic [IDX_W-1:0]  job_w;
    logic [IDX_W-1:0]  active_reg, active_next;
    logic [TIME_W-1:0] mark_reg, mark_next;
    logic [SIDX_W-1:0] stop_sum;
    logic              stop_err;
    logic              is_charge;
    err_t              err;
    stack_ctl_t        stk_ctl;
    stack_sts_t        stk_sts;
    logic [IDX_W-1:0]  stk_top;
    logic [CNT_W-1:0]  max_next;
    totals_ctl_t       tot_ctl;
    logic [IDX_W-1:0]  rd_idx;
    logic [TOTAL_W-1:0] rd_total;

    assign op        = op_t'(op_reg);
    assign job_w     = job_wrap(job_reg);
    assign stop_sum  = SIDX_W'(stop_base_reg) + SIDX_W'(mode_reg);
    assign stop_err  = int'(stop_sum) >= NUM_JOBS;
    assign is_charge = (op == OP_SWITCH) || (op == OP_PUSH) || (op == OP_POP);

    always_comb begin
        active_next = active_reg;
        mark_next   = mark_reg;
        err         = ERR_NONE;
        stk_ctl     = '0;
        rd_idx      = job_w;
        tot_ctl.clear      = 1'b0;
        tot_ctl.charge     = 1'b0;
        tot_ctl.stop_en    = 1'b0;
        tot_ctl.rd_zero    = 1'b0;
        tot_ctl.d_active   = entry_reg - mark_reg;
        tot_ctl.d_overhead = exit_reg - entry_reg;
        tot_ctl.amount     = amount_reg;
        if (advance) begin
            tot_ctl.charge = is_charge;
            if (is_charge || (op == OP_INIT)) begin
                mark_next = exit_reg;
            end
            case (op)
                OP_INIT: begin
                    tot_ctl.clear = 1'b1;
                    stk_ctl.clear = 1'b1;
                    active_next   = job_w;
                end
                OP_SWITCH: active_next = job_w;
                OP_PUSH: begin
                    stk_ctl.push = 1'b1;
                    active_next  = job_w;
                    if (stk_sts.full) begin
                        err = ERR_PUSH_FULL;
                    end
                end
                OP_POP: begin
                    stk_ctl.pop = 1'b1;
                    if (stk_sts.empty) begin
                        err = ERR_POP_EMPTY;
                    end else begin
                        active_next = stk_top;
                    end
                end
                OP_STOP: begin
                    rd_idx = IDX_W'(stop_sum);
                    if (stop_err) begin
                        err             = ERR_STOP_RANGE;
                        tot_ctl.rd_zero = 1'b1;
                    end else begin
                        tot_ctl.stop_en = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            mark_reg   <= '0;
        end else begin
            active_reg <= active_next;
            mark_reg   <= mark_next;
        end
    end

    nja_stack #(
        .STACK_SLOTS (STACK_SLOTS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (stk_ctl),
        .push_data (active_reg),
        .top       (stk_top),
        .sts       (stk_sts),
        .max_next  (max_next)
    );

    nja_totals #(
        .NUM_JOBS (NUM_JOBS),
        .IDX_W    (IDX_W)
    ) u_totals (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (tot_ctl),
        .act_idx  (active_reg),
        .ovh_idx  (job_wrap(overhead_job_reg)),
        .stop_idx (IDX_W'(stop_sum)),
        .rd_idx   (rd_idx),
        .upd_en   (advance),
        .rd_total (rd_total)
    );

    // result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_total_time    <= rd_total;
            m_current_job   <= JOB_W'(active_next);
            m_deepest_level <= LEVEL_W'(max_next);
            m_error_code    <= err;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- sv/nja_checker.sv -----
module nja_checker #(
    parameter int NUM_JOBS    = nja_pkg::DEF_NUM_JOBS,
    parameter int STACK_SLOTS = nja_pkg::DEF_STACK_SLOTS
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [nja_pkg::TOTAL_W-1:0]     m_total_time,
    input logic [nja_pkg::JOB_W-1:0]       m_current_job,
    input logic [nja_pkg::LEVEL_W-1:0]     m_deepest_level,
    input logic [nja_pkg::ERR_W-1:0]       m_error_code
);
    import nja_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_time)
            && $stable(m_current_job) && $stable(m_error_code))
        else $error("stalled result changed");

    a_stop_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code == ERR_STOP_RANGE) |-> (m_total_time == '0))
        else $error("out-of-range stop job reported a nonzero total");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_deepest_level) <= STACK_SLOTS || STACK_SLOTS > 15))
        else $error("deepest level beyond stack size");

    a_job_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_current_job) < NUM_JOBS))
        else $error("current job outside job range");

endmodule

bind nested_job_time_accounting nja_checker #(
    .NUM_JOBS    (NUM_JOBS),
    .STACK_SLOTS (STACK_SLOTS)
) u_nja_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_total_time    (m_total_time),
    .m_current_job   (m_current_job),
    .m_deepest_level (m_deepest_level),
    .m_error_code    (m_error_code)
);

// ----- sim/tb_nested_job_time_accounting.sv -----
`timescale 1ns / 1ps

module tb_nested_job_time_accounting;
    import nja_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 242;

    // register settings per random phase; the first phase runs with no idling
    localparam logic [JOB_W-1:0] PHASE_OVH  [NUM_PHASES] = '{4'd3, 4'd0, 4'd15, 4'd15, 4'd9, 4'd5};
    localparam logic [JOB_W-1:0] PHASE_BASE [NUM_PHASES] = '{4'd14, 4'd0, 4'd15, 4'd12, 4'd13, 4'd2};

    typedef struct packed {
        logic [OPCODE_W-1:0]    op;
        logic [JOB_W-1:0]       job;
        logic [TIME_W-1:0]      t_in;
        logic [TIME_W-1:0]      t_out;
        logic [TIME_W-1:0]      amount;
        logic [STOP_MODE_W-1:0] mode;
    } event_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [JOB_W-1:0]   job;
        logic [LEVEL_W-1:0] level;
        err_t               err;
    } result_t;

    typedef struct packed {
        logic       is_cfg;
        logic [3:0] cfg_ovh;
        logic [3:0] cfg_base;
        event_t     ev;
        logic       typed;
        result_t    want;
    } plan_row_t;

    localparam result_t NO_RESULT = '0;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [OPCODE_W-1:0]    s_opcode      = '0;
    logic [JOB_W-1:0]       s_job         = '0;
    logic [TIME_W-1:0]      s_entry_time  = '0;
    logic [TIME_W-1:0]      s_exit_time   = '0;
    logic [TIME_W-1:0]      s_stop_amount = '0;
    logic [STOP_MODE_W-1:0] s_stop_mode   = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [TOTAL_W-1:0]     m_total_time;
    logic [JOB_W-1:0]       m_current_job;
    logic [LEVEL_W-1:0]     m_deepest_level;
    logic [ERR_W-1:0]       m_error_code;

    nested_job_time_accounting i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_job           (s_job),
        .s_entry_time    (s_entry_time),
        .s_exit_time     (s_exit_time),
        .s_stop_amount   (s_stop_amount),
        .s_stop_mode     (s_stop_mode),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_total_time    (m_total_time),
        .m_current_job   (m_current_job),
        .m_deepest_level (m_deepest_level),
        .m_error_code    (m_error_code)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // accounting state as the block should hold it
    logic [JOB_W-1:0]   reg_overhead  = RST_OVERHEAD_JOB;
    logic [JOB_W-1:0]   reg_stop_base = RST_STOP_BASE_JOB;
    logic [JOB_W-1:0]   acc_active    = '0;
    logic [TIME_W-1:0]  acc_mark      = '0;
    int                 acc_depth     = 0;
    int                 acc_peak      = 0;
    logic [JOB_W-1:0]   acc_saved  [DEF_STACK_SLOTS];
    logic [TOTAL_W-1:0] acc_totals [DEF_NUM_JOBS] = '{default: '0};

    result_t     pending_results [$];
    int unsigned failures = 0;
    bit          pacing   = 1'b1;

    function automatic void charge_elapsed(input logic [TIME_W-1:0] t_in,
                                           input logic [TIME_W-1:0] t_out);
        logic [TIME_W-1:0] run_span;
        logic [TIME_W-1:0] ovh_span;
        run_span = t_in - acc_mark;
        ovh_span = t_out - t_in;
        acc_totals[acc_active]   = acc_totals[acc_active] + {32'd0, run_span};
        acc_totals[reg_overhead] = acc_totals[reg_overhead] + {32'd0, ovh_span};
        acc_mark = t_out;
    endfunction

    function automatic result_t account_event(input event_t ev);
        result_t res;
        int      stop_job;
        logic    stop_hit;
        res      = NO_RESULT;
        res.err  = ERR_NONE;
        stop_hit = 1'b0;
        case (ev.op)
            OP_INIT: begin
                foreach (acc_totals[j]) acc_totals[j] = '0;
                acc_depth  = 0;
                acc_peak   = 0;
                acc_active = ev.job;
                acc_mark   = ev.t_out;
            end
            OP_SWITCH: begin
                charge_elapsed(ev.t_in, ev.t_out);
                acc_active = ev.job;
            end
            OP_PUSH: begin
                charge_elapsed(ev.t_in, ev.t_out);
                if (acc_depth >= DEF_STACK_SLOTS) begin
                    res.err = ERR_PUSH_FULL;
                end else begin
                    acc_saved[acc_depth] = acc_active;
                    acc_depth++;
                    if (acc_depth > acc_peak) acc_peak = acc_depth;
                end
                acc_active = ev.job;
            end
            OP_POP: begin
                charge_elapsed(ev.t_in, ev.t_out);
                if (acc_depth == 0) begin
                    res.err = ERR_POP_EMPTY;
                end else begin
                    acc_depth--;
                    acc_active = acc_saved[acc_depth];
                end
            end
            OP_STOP: begin
                stop_hit = 1'b1;
                stop_job = int'(reg_stop_base) + int'(ev.mode);
                if (stop_job >= DEF_NUM_JOBS) begin
                    res.err = ERR_STOP_RANGE;
                end else begin
                    acc_totals[stop_job] = acc_totals[stop_job] + {32'd0, ev.amount};
                    res.total = acc_totals[stop_job];
                end
            end
            default: begin
            end
        endcase
        if (!stop_hit) res.total = acc_totals[ev.job];
        res.job   = acc_active;
        res.level = LEVEL_W'(acc_peak);
        return res;
    endfunction

    function automatic plan_row_t op_row(input logic [OPCODE_W-1:0] op,
                                         input logic [JOB_W-1:0] job,
                                         input logic [TIME_W-1:0] t_in,
                                         input logic [TIME_W-1:0] t_out,
                                         input logic [TIME_W-1:0] amount,
                                         input logic [STOP_MODE_W-1:0] mode);
        plan_row_t row;
        row           = '0;
        row.ev.op     = op;
        row.ev.job    = job;
        row.ev.t_in   = t_in;
        row.ev.t_out  = t_out;
        row.ev.amount = amount;
        row.ev.mode   = mode;
        row.want      = NO_RESULT;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [3:0] ovh, input logic [3:0] base);
        plan_row_t row;
        row          = '0;
        row.is_cfg   = 1'b1;
        row.cfg_ovh  = ovh;
        row.cfg_base = base;
        return row;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_event(input event_t ev, input logic typed, input result_t want);
        result_t predicted;
        while (pacing && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= ev.op;
        s_job         <= ev.job;
        s_entry_time  <= ev.t_in;
        s_exit_time   <= ev.t_out;
        s_stop_amount <= ev.amount;
        s_stop_mode   <= ev.mode;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = account_event(ev);
        pending_results.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // drain everything in flight, then write both registers
    task automatic settle_and_configure(input logic [3:0] ovh, input logic [3:0] base);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_OVERHEAD_JOB;
        cfg_wdata <= ovh;
        @(negedge aclk);
        cfg_index <= CFG_STOP_BASE;
        cfg_wdata <= base;
        @(negedge aclk);
        cfg_wr_en     <= 1'b0;
        reg_overhead  = ovh;
        reg_stop_base = base;
    endtask

    always @(negedge aclk) begin
        m_ready <= !(pacing && $urandom_range(99) < 37);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: total_time %0h current_job %0d",
                       m_total_time, m_current_job);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (m_total_time !== want.total) begin
                    $error("total_time: expected %0h, got %0h", want.total, m_total_time);
                    failures++;
                end
                if (m_current_job !== want.job) begin
                    $error("current_job: expected %0d, got %0d", want.job, m_current_job);
                    failures++;
                end
                if (m_deepest_level !== want.level) begin
                    $error("deepest_level: expected %0d, got %0d",
                           want.level, m_deepest_level);
                    failures++;
                end
                if (m_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, m_error_code);
                    failures++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        plan_row_t         directed_plan [$];
        plan_row_t         row;
        event_t            ev;
        int                pick;
        logic [TIME_W-1:0] wall_us;

        row = op_row(OP_READ, 4'd0, 32'd0, 32'd0, 32'd0, 2'd0);
        row.typed = 1'b1;
        row.want  = '{64'd0, 4'd0, 4'd0, ERR_NONE};
        directed_plan.push_back(row);
        row = op_row(OP_POP, 4'd3, 32'd100, 32'd150, 32'd0, 2'd0);
        row.typed = 1'b1;
        row.want  = '{64'd0, 4'd0, 4'd0, ERR_POP_EMPTY};
        directed_plan.push_back(row);
        row = op_row(OP_INIT, 4'd5, 32'd0, 32'd1000, 32'd0, 2'd0);
        row.typed = 1'b1;
        row.want  = '{64'd0, 4'd5, 4'd0, ERR_NONE};
        directed_plan.push_back(row);
        // timestamps wrap between the switch's entry and exit times
        directed_plan.push_back(op_row(OP_SWITCH, 4'd2, 32'hFFFF_FFFF, 32'd0, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_PUSH, 4'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_PUSH, 4'd4, 32'd200, 32'd210, 32'd0, 2'd1));
        directed_plan.push_back(op_row(OP_PUSH, 4'd8, 32'd300, 32'd333, 32'd0, 2'd2));
        directed_plan.push_back(op_row(OP_PUSH, 4'd15, 32'd400, 32'd401, 32'd0, 2'd3));
        directed_plan.push_back(op_row(OP_PUSH, 4'd0, 32'd500, 32'd520, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_PUSH, 4'd10, 32'd600, 32'd650, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_PUSH, 4'd6, 32'd700, 32'd777, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_PUSH, 4'd9, 32'd800, 32'd888, 32'd0, 2'd0));
        // stack full: flagged, active job still moves
        directed_plan.push_back(op_row(OP_PUSH, 4'd11, 32'd900, 32'd905, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_READ, 4'd15, 32'd0, 32'd0, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_POP, 4'd0, 32'd1000, 32'd1010, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_POP, 4'd9, 32'd1100, 32'd1111, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_STOP, 4'd12, 32'd0, 32'd0, 32'hFFFF_FFFF, 2'd0));
        directed_plan.push_back(op_row(OP_STOP, 4'd15, 32'd0, 32'd0, 32'd1, 2'd3));
        directed_plan.push_back(cfg_row(4'd0, 4'd15));
        // stop job past the last job
        directed_plan.push_back(op_row(OP_STOP, 4'd0, 32'd0, 32'd0, 32'd55, 2'd1));
        directed_plan.push_back(op_row(OP_SWITCH, 4'd7, 32'd1200, 32'd1300, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_RSVD6, 4'd15, 32'd5, 32'd6, 32'd7, 2'd3));
        directed_plan.push_back(op_row(OP_RSVD7, 4'd12, 32'd8, 32'd9, 32'd10, 2'd2));
        directed_plan.push_back(op_row(OP_READ, 4'd0, 32'd0, 32'd0, 32'd0, 2'd0));
        directed_plan.push_back(cfg_row(4'd15, 4'd0));
        directed_plan.push_back(op_row(OP_STOP, 4'd3, 32'd0, 32'd0, 32'd7, 2'd3));
        directed_plan.push_back(op_row(OP_INIT, 4'd15, 32'd0, 32'hFFFF_FFFF, 32'd0, 2'd0));
        directed_plan.push_back(op_row(OP_POP, 4'd15, 32'd3, 32'd4, 32'd0, 2'd0));

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                settle_and_configure(directed_plan[i].cfg_ovh, directed_plan[i].cfg_base);
            end else begin
                send_event(directed_plan[i].ev, directed_plan[i].typed, directed_plan[i].want);
            end
        end

        wall_us = $urandom;
        for (int p = 0; p < NUM_PHASES; p++) begin
            pacing = (p != 0);
            settle_and_configure(PHASE_OVH[p], PHASE_BASE[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 80) begin
                    // plausible traffic: time moves forward, push and pop about even
                    pick = $urandom_range(99);
                    if (pick < 2)       ev.op = OP_INIT;
                    else if (pick < 22) ev.op = OP_SWITCH;
                    else if (pick < 50) ev.op = OP_PUSH;
                    else if (pick < 78) ev.op = OP_POP;
                    else if (pick < 88) ev.op = OP_STOP;
                    else if (pick < 97) ev.op = OP_READ;
                    else                ev.op = $urandom_range(1) ? OP_RSVD7 : OP_RSVD6;
                    ev.job    = JOB_W'($urandom);
                    ev.t_in   = wall_us + $urandom_range(2000);
                    ev.t_out  = ev.t_in + $urandom_range(200);
                    ev.amount = $urandom_range(100000);
                    ev.mode   = STOP_MODE_W'($urandom);
                    wall_us   = ev.t_out;
                end else begin
                    ev.op     = OPCODE_W'($urandom);
                    ev.job    = JOB_W'($urandom);
                    ev.t_in   = $urandom;
                    ev.t_out  = $urandom;
                    ev.amount = $urandom;
                    ev.mode   = STOP_MODE_W'($urandom);
                end
                send_event(ev, 1'b0, NO_RESULT);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
